FILE: rtl/bsa_pkg.sv
// Shared types, constants and the microprogram of the barometer sample averager.
package bsa_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 255;

  localparam int unsigned STATUS_W = 8;
  localparam int unsigned TRAW_W   = 16;
  localparam int unsigned PRAW_W   = 24;
  localparam int unsigned AVG_W    = 19;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned PA_MAX   = 409599;

  // Temperature formula for sensor kind 0: floor(raw*5/24) + 4250.
  // The bias makes raw*5 non-negative, the divide by 24 becomes a shift by 3
  // and a multiply by the reciprocal of 3, and the bias is removed afterwards.
  localparam int unsigned TBIAS       = 24 * 6827;
  localparam int unsigned TOFFSET     = 6827 - 4250;
  localparam int unsigned RECIP3      = 43691;
  localparam int unsigned RECIP3_SHFT = 17;
  localparam int unsigned PSCALE      = 100;
  localparam int unsigned PSHIFT      = 12;

  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // Named program addresses; all but STEP_TEMP are jump targets.
  localparam pc_t STEP_IDLE   = 4'd0;
  localparam pc_t STEP_TEMP   = 4'd2;
  localparam pc_t STEP_PRESS  = 4'd4;
  localparam pc_t STEP_REPORT = 4'd6;
  localparam pc_t STEP_DIV    = 4'd7;
  localparam pc_t STEP_WAIT   = 4'd8;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_TPREP,
    OP_TWRITE,
    OP_PMUL,
    OP_PACC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_OUT_LOAD
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_VALID,
    C_IS_REPORT,
    C_NO_TEMP,
    C_NO_PRESS,
    C_COUNT_ZERO,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic is_report;
    logic temp_rdy;
    logic press_ok;
    logic count_zero;
    logic div_more;
    logic out_busy;
  } flags_t;

  // The microprogram. A step runs its operation, then jumps to its target
  // when its condition holds and otherwise falls through to the next step.
  function automatic ctl_t ucode(input pc_t pc);
    ctl_t w;
    unique case (pc)
      4'd0:    w = '{op: OP_ACCEPT,   cond: C_NOT_VALID,  target: STEP_IDLE};
      4'd1:    w = '{op: OP_NONE,     cond: C_IS_REPORT,  target: STEP_REPORT};
      4'd2:    w = '{op: OP_TPREP,    cond: C_NO_TEMP,    target: STEP_PRESS};
      4'd3:    w = '{op: OP_TWRITE,   cond: C_NEVER,      target: STEP_IDLE};
      4'd4:    w = '{op: OP_PMUL,     cond: C_NO_PRESS,   target: STEP_IDLE};
      4'd5:    w = '{op: OP_PACC,     cond: C_ALWAYS,     target: STEP_IDLE};
      4'd6:    w = '{op: OP_DIV_INIT, cond: C_COUNT_ZERO, target: STEP_IDLE};
      4'd7:    w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,   target: STEP_DIV};
      4'd8:    w = '{op: OP_NONE,     cond: C_OUT_BUSY,   target: STEP_WAIT};
      4'd9:    w = '{op: OP_OUT_LOAD, cond: C_ALWAYS,     target: STEP_IDLE};
      default: w = '{op: OP_NONE,     cond: C_ALWAYS,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/bsa_ifs.sv
// Valid/ready channel interfaces for sample requests and averaged results.
interface bsa_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [bsa_pkg::STATUS_W-1:0]        status;
  logic signed [bsa_pkg::TRAW_W-1:0]   raw_temp;
  logic [bsa_pkg::PRAW_W-1:0]          raw_pressure;

  modport source (output valid, req_type, status, raw_temp, raw_pressure, input ready);
  modport sink   (input valid, req_type, status, raw_temp, raw_pressure, output ready);
endinterface

interface bsa_out_if;
  logic                                valid;
  logic                                ready;
  logic [bsa_pkg::AVG_W-1:0]           avg_pressure_pa;
  logic signed [bsa_pkg::TEMP_W-1:0]   temp_centideg;

  modport source (output valid, avg_pressure_pa, temp_centideg, input ready);
  modport sink   (input valid, avg_pressure_pa, temp_centideg, output ready);
endinterface

FILE: rtl/baro_sample_average.sv
// Top level of the barometer sample averager.
//
// Usage: the in_ch channel takes one request per handshake. A sample request
// (req_type 0) updates the held temperature when status bit 1 is set and adds
// the scaled pressure to a running sum when status bit 0 is set and fewer than
// MAX_SAMPLES are summed; it never produces a result. A report request
// (req_type 1) produces one result on out_ch with the truncated average
// pressure in pascals and the held temperature in centidegrees, then clears
// the sum and count; with no samples collected it produces nothing.
// Each request is finished before the next one is accepted. The serial
// restoring divider of a report forms the quotient one bit per cycle, one
// bit for each bit of the pressure sum (27 bits at the default MAX_SAMPLES).
// The result is loaded into the output register once the quotient is done
// and any earlier result has been taken.
// The result sits in an output register, so a stalled receiver does not block
// new samples; a second report waits only until the earlier result is taken.
// Reset (synchronous, active low) clears the sum, count and held temperature
// and sets sensor_kind to 1. cfg_we writes sensor_kind from cfg_wdata;
// the user must use it only while the block is idle, which is not enforced.
module baro_sample_average #(
  parameter int unsigned MAX_SAMPLES = bsa_pkg::MAX_SAMPLES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  bsa_in_if.sink    in_ch,
  bsa_out_if.source out_ch
);

  // The sequencer steps through the control store and the datapath
  // executes one operation per step, reporting branch conditions back.
  bsa_pkg::ctl_t   ctl;
  bsa_pkg::flags_t flags;

  bsa_ucode_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  bsa_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .flags     (flags),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule

FILE: rtl/bsa_ucode_seq.sv
// Step counter and control store of the microcoded sequencer.
module bsa_ucode_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  bsa_pkg::flags_t flags,
  output bsa_pkg::ctl_t   ctl
);

  bsa_pkg::pc_t pc_r, pc_nxt;
  logic         take;

  always_comb begin
    ctl = bsa_pkg::ucode(pc_r);
  end

  always_comb begin
    unique case (ctl.cond)
      bsa_pkg::C_NEVER:      take = 1'b0;
      bsa_pkg::C_ALWAYS:     take = 1'b1;
      bsa_pkg::C_NOT_VALID:  take = !flags.in_valid;
      bsa_pkg::C_IS_REPORT:  take = flags.is_report;
      bsa_pkg::C_NO_TEMP:    take = !flags.temp_rdy;
      bsa_pkg::C_NO_PRESS:   take = !flags.press_ok;
      bsa_pkg::C_COUNT_ZERO: take = flags.count_zero;
      bsa_pkg::C_DIV_MORE:   take = flags.div_more;
      bsa_pkg::C_OUT_BUSY:   take = flags.out_busy;
      default:               take = 1'b1;
    endcase
    pc_nxt = take ? ctl.target : pc_r + bsa_pkg::pc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= bsa_pkg::STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/bsa_datapath.sv
// Datapath: input capture, temperature conversion, pressure sum and serial divider.
module bsa_datapath #(
  parameter int unsigned MAX_SAMPLES = bsa_pkg::MAX_SAMPLES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bsa_pkg::ctl_t   ctl,
  output bsa_pkg::flags_t flags,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  bsa_in_if.sink          in_ch,
  bsa_out_if.source       out_ch
);

  localparam int unsigned CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W    =
    $clog2(64'(MAX_SAMPLES) * 64'(bsa_pkg::PA_MAX) + 64'd1);
  localparam int unsigned ITER_W   = $clog2(SUM_W + 1);
  localparam int unsigned TV_W     = 16;
  localparam int unsigned PA_W     = bsa_pkg::AVG_W;
  localparam int unsigned PP_W     = bsa_pkg::PRAW_W + 7;
  localparam int unsigned RECIP3_W = 17;

  logic                               kind_r;
  logic                               req_r;
  logic [1:0]                         stat_r;
  logic signed [bsa_pkg::TRAW_W-1:0]  traw_r;
  logic [bsa_pkg::PRAW_W-1:0]         praw_r;
  logic [TV_W-1:0]                    tv_r;
  logic [PA_W-1:0]                    ps_r;
  logic [SUM_W-1:0]                   sum_r;
  logic [CNT_W-1:0]                   count_r;
  logic signed [bsa_pkg::TEMP_W-1:0]  held_r;
  logic [SUM_W-1:0]                   q_r;
  logic [CNT_W-1:0]                   rem_r;
  logic [ITER_W-1:0]                  iter_r;
  logic                               out_valid_r;
  logic [bsa_pkg::AVG_W-1:0]          avg_r;
  logic signed [bsa_pkg::TEMP_W-1:0]  tout_r;

  logic                               in_take;
  logic signed [19:0]                 t5;
  logic signed [19:0]                 tbiased;
  logic [TV_W+RECIP3_W-1:0]           tprod;
  logic [TV_W-1:0]                    tquot;
  logic [PP_W-1:0]                    pprod;
  logic [CNT_W:0]                     trial;
  logic                               fits;

  assign in_ch.ready = (ctl.op == bsa_pkg::OP_ACCEPT);
  assign in_take     = in_ch.valid && in_ch.ready;

  // Temp: biased raw*5, /24 as shift and reciprocal; pressure scale; divide trial.
  always_comb begin
    t5      = (20'(traw_r) <<< 2) + 20'(traw_r);
    tbiased = t5 + 20'(bsa_pkg::TBIAS);
    tprod   = tv_r * RECIP3_W'(bsa_pkg::RECIP3);
    tquot   = tprod[bsa_pkg::RECIP3_SHFT +: TV_W];
    pprod   = praw_r * 7'(bsa_pkg::PSCALE);
    trial   = {rem_r, q_r[SUM_W-1]};
    fits    = (trial >= {1'b0, count_r});
  end

  always_comb begin
    flags.in_valid   = in_ch.valid;
    flags.is_report  = req_r;
    flags.temp_rdy   = stat_r[1];
    flags.press_ok   = stat_r[0] && (count_r != CNT_W'(MAX_SAMPLES));
    flags.count_zero = (count_r == '0);
    flags.div_more   = (iter_r != ITER_W'(1));
    flags.out_busy   = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r  <= in_ch.req_type;
      stat_r <= in_ch.status[1:0];
      traw_r <= in_ch.raw_temp;
      praw_r <= in_ch.raw_pressure;
    end
    unique case (ctl.op)
      bsa_pkg::OP_TPREP:    tv_r <= tbiased[18:3];
      bsa_pkg::OP_PMUL:     ps_r <= pprod[bsa_pkg::PSHIFT +: PA_W];
      bsa_pkg::OP_DIV_INIT: begin
        q_r    <= sum_r;
        rem_r  <= '0;
        iter_r <= ITER_W'(SUM_W);
      end
      bsa_pkg::OP_DIV_STEP: begin
        q_r    <= {q_r[SUM_W-2:0], fits};
        rem_r  <= fits ? CNT_W'(trial - {1'b0, count_r}) : trial[CNT_W-1:0];
        iter_r <= iter_r - ITER_W'(1);
      end
      bsa_pkg::OP_OUT_LOAD: begin
        avg_r  <= q_r[bsa_pkg::AVG_W-1:0];
        tout_r <= held_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= 1'b1;
      sum_r       <= '0;
      count_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        kind_r <= cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (ctl.op)
        bsa_pkg::OP_TWRITE: begin
          held_r <= kind_r ? traw_r
                           : bsa_pkg::TEMP_W'(tquot - TV_W'(bsa_pkg::TOFFSET));
        end
        bsa_pkg::OP_PACC: begin
          sum_r   <= sum_r + SUM_W'(ps_r);
          count_r <= count_r + CNT_W'(1);
        end
        bsa_pkg::OP_OUT_LOAD: begin
          sum_r       <= '0;
          count_r     <= '0;
          out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.avg_pressure_pa = avg_r;
  assign out_ch.temp_centideg   = tout_r;

endmodule
